FILE: hw/rtl/lfsia_pkg.sv
// Shared constants and types for the lowest free seat interval allocator.
package lfsia_pkg;

   localparam int NUM_SEATS = 64;
   localparam int TIME_BITS = 32;

   localparam int SEAT_W  = (NUM_SEATS > 1) ? $clog2(NUM_SEATS) : 1;
   localparam int CNT_W   = $clog2(NUM_SEATS + 1);
   localparam int USE_W   = 16;
   localparam int FIELD_TIME_W = 32;
   localparam int FIELD_SEAT_W = 6;
   localparam int FIELD_CNT_W  = 7;

   localparam int REQ_DATA_W = 2 * FIELD_TIME_W;
   localparam int RSP_BITS   = FIELD_SEAT_W + USE_W + 2 * FIELD_CNT_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [USE_W-1:0] USE_MAX = '1;

   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [SEAT_W-1:0]    seat_type;
   typedef logic [CNT_W-1:0]     cnt_type;
   typedef logic [USE_W-1:0]     use_type;

   typedef struct packed {
      seat_type end_rd_addr;
      logic     end_wr_en;
      seat_type end_wr_addr;
      time_type end_wr_data;
      seat_type use_rd_addr;
      logic     use_wr_en;
      seat_type use_wr_addr;
      use_type  use_wr_data;
   } mem_cmd_type;

   typedef struct packed {
      time_type end_rd_data;
      use_type  use_rd_data;
   } mem_rsp_type;

   typedef struct packed {
      logic                    status;
      logic [FIELD_SEAT_W-1:0] seat_index;
      use_type                 seat_use_count;
      logic [FIELD_CNT_W-1:0]  busy_count;
      logic [FIELD_CNT_W-1:0]  peak_busy;
   } result_type;

endpackage

FILE: hw/rtl/lfsia_seat_mem.sv
// Per-seat end time and use count memories with registered reads.
module lfsia_seat_mem
   import lfsia_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mem_cmd_type cmd,
   output mem_rsp_type rsp
);

   time_type                 end_mem [NUM_SEATS];
   use_type                  use_mem [NUM_SEATS];
   logic [NUM_SEATS-1:0]     use_vld_ff;
   time_type                 end_rd_ff;
   use_type                  use_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.end_wr_en) begin
         end_mem[cmd.end_wr_addr] <= cmd.end_wr_data;
      end
      end_rd_ff <= end_mem[cmd.end_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.use_wr_en) begin
         use_mem[cmd.use_wr_addr] <= cmd.use_wr_data;
      end
      use_rd_ff <= use_mem[cmd.use_rd_addr];
   end

   // unwritten counts read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         use_vld_ff <= '0;
      end else if (cmd.use_wr_en) begin
         use_vld_ff[cmd.use_wr_addr] <= 1'b1;
      end
   end

   logic use_vld_rd_ff;

   always_ff @(posedge clock) begin
      use_vld_rd_ff <= use_vld_ff[cmd.use_rd_addr];
   end

   assign rsp.end_rd_data = end_rd_ff;
   assign rsp.use_rd_data = use_vld_rd_ff ? use_rd_ff : '0;

endmodule

FILE: hw/rtl/lfsia_ctrl.sv
// Scan sequencer: releases expired seats, picks the lowest free seat, updates counters.
module lfsia_ctrl
   import lfsia_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  time_type    req_start,
   input  time_type    req_end,
   output mem_cmd_type cmd,
   input  mem_rsp_type rsp,
   input  logic        out_free,
   output logic        res_load,
   output result_type  res
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_UREAD  = 3'd2;
   localparam logic [2:0] ST_UWRITE = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [NUM_SEATS-1:0] busy_ff, busy_in;
   cnt_type              busy_total_ff, busy_total_in;
   cnt_type              peak_ff, peak_in;
   cnt_type              issue_ff, issue_in;
   seat_type             cmp_idx_ff, cmp_idx_in;
   logic                 cmp_vld_ff, cmp_vld_in;
   logic                 found_ff, found_in;
   seat_type             chosen_ff, chosen_in;
   use_type              uses_ff, uses_in;
   time_type             start_ff, start_in;
   time_type             stop_ff, stop_in;

   logic    cur_busy;
   logic    expire;
   logic    take;
   logic    last_cmp;
   cnt_type busy_inc;

   always_comb begin
      state_in      = state_ff;
      busy_in       = busy_ff;
      busy_total_in = busy_total_ff;
      peak_in       = peak_ff;
      issue_in      = issue_ff;
      cmp_idx_in    = cmp_idx_ff;
      cmp_vld_in    = 1'b0;
      found_in      = found_ff;
      chosen_in     = chosen_ff;
      uses_in       = uses_ff;
      start_in      = start_ff;
      stop_in       = stop_ff;
      req_ready     = 1'b0;
      res_load      = 1'b0;
      busy_inc      = busy_total_ff + cnt_type'(1);

      cmd.end_rd_addr = issue_ff[SEAT_W-1:0];
      cmd.end_wr_en   = 1'b0;
      cmd.end_wr_addr = chosen_ff;
      cmd.end_wr_data = stop_ff;
      cmd.use_rd_addr = chosen_ff;
      cmd.use_wr_en   = 1'b0;
      cmd.use_wr_addr = chosen_ff;
      cmd.use_wr_data = uses_ff;

      cur_busy = busy_ff[cmp_idx_ff];
      expire   = cmp_vld_ff && cur_busy && (rsp.end_rd_data <= start_ff);
      take     = cmp_vld_ff && (!cur_busy || expire) && !found_ff;
      last_cmp = cmp_vld_ff && (cmp_idx_ff == seat_type'(NUM_SEATS - 1));

      res.status         = !found_ff;
      res.seat_index     = found_ff ? FIELD_SEAT_W'(chosen_ff) : '0;
      res.seat_use_count = found_ff ? uses_ff : '0;
      res.busy_count     = FIELD_CNT_W'(busy_total_ff);
      res.peak_busy      = FIELD_CNT_W'(peak_ff);

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               start_in = req_start;
               stop_in  = req_end;
               issue_in = '0;
               found_in = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue_ff < cnt_type'(NUM_SEATS)) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = issue_ff[SEAT_W-1:0];
               issue_in   = issue_ff + cnt_type'(1);
            end
            if (expire) begin
               busy_in[cmp_idx_ff] = 1'b0;
               busy_total_in       = busy_total_ff - cnt_type'(1);
            end
            if (take) begin
               found_in  = 1'b1;
               chosen_in = cmp_idx_ff;
            end
            if (last_cmp) begin
               state_in = (found_ff || take) ? ST_UREAD : ST_DONE;
            end
         end
         ST_UREAD: begin
            state_in = ST_UWRITE;
         end
         ST_UWRITE: begin
            uses_in = (rsp.use_rd_data == USE_MAX) ? USE_MAX
                                                   : rsp.use_rd_data + use_type'(1);
            cmd.use_wr_en       = 1'b1;
            cmd.use_wr_data     = uses_in;
            cmd.end_wr_en       = 1'b1;
            busy_in[chosen_ff]  = 1'b1;
            busy_total_in       = busy_inc;
            if (busy_inc > peak_ff) begin
               peak_in = busy_inc;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               res_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         busy_ff       <= '0;
         busy_total_ff <= '0;
         peak_ff       <= '0;
         cmp_vld_ff    <= 1'b0;
         found_ff      <= 1'b0;
         issue_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         busy_ff       <= busy_in;
         busy_total_ff <= busy_total_in;
         peak_ff       <= peak_in;
         cmp_vld_ff    <= cmp_vld_in;
         found_ff      <= found_in;
         issue_ff      <= issue_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= cmp_idx_in;
      chosen_ff  <= chosen_in;
      uses_ff    <= uses_in;
      start_ff   <= start_in;
      stop_ff    <= stop_in;
   end

endmodule

FILE: hw/rtl/lowest_free_seat_interval_allocator_top.sv
// Top level of the lowest free seat interval allocator.
// A request is accepted only in the idle state, so a new request waits until the
// result of the last one is loaded into the output register; a dropped request
// skips the use count read and write. The scan reads one seat per cycle through
// the end time memory read port.
// Reset (synchronous): all seats free, use counts, busy and peak counts zero.
module lowest_free_seat_interval_allocator_top
   import lfsia_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // start_time, end_time
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // seat_index, seat_use_count, busy_count, peak_busy
   output logic                  rsp_tuser    // status
);

   mem_cmd_type mem_cmd;
   mem_rsp_type mem_rsp;
   result_type  res;
   logic        res_load;
   logic        out_free;
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   result_type  rsp_data_ff;

   lfsia_seat_mem u_mem (
      .clock (clock),
      .reset (reset),
      .cmd   (mem_cmd),
      .rsp   (mem_rsp)
   );

   lfsia_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_start (time_type'(req_tdata[FIELD_TIME_W-1:0])),
      .req_end   (time_type'(req_tdata[REQ_DATA_W-1:FIELD_TIME_W])),
      .cmd       (mem_cmd),
      .rsp       (mem_rsp),
      .out_free  (out_free),
      .res_load  (res_load),
      .res       (res)
   );

   assign out_free      = !rsp_tvalid_ff || rsp_tready;
   assign rsp_tvalid_in = res_load || (rsp_tvalid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_data_ff.status;
   assign rsp_tdata  = RSP_DATA_W'({rsp_data_ff.peak_busy, rsp_data_ff.busy_count,
                                    rsp_data_ff.seat_use_count, rsp_data_ff.seat_index});

endmodule

FILE: hw/rtl/lfsia_checker.sv
// Port-level checks for the allocator top level, attached by bind.
module lfsia_checker
   import lfsia_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   ap_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   ap_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while scan in progress");

   ap_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[21:0] == 22'd0)
      else $error("dropped request reports a seat");

   ap_assigned: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[21:6] != 16'd0 && rsp_tdata[28:22] != 7'd0)
      else $error("assigned seat with zero count");

   ap_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[35:29] >= rsp_tdata[28:22])
      else $error("peak below busy count");

endmodule

bind lowest_free_seat_interval_allocator_top lfsia_checker u_lfsia_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: bench/lowest_free_seat_interval_allocator_checker.sv
// Scoreboard for the seat allocator: predicts each booking result and compares.
module lowest_free_seat_interval_allocator_checker
   import lfsia_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // start_time, end_time
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // seat_index, seat_use_count, busy_count, peak_busy
   input  logic                  rsp_tuser,   // status
   output int                    error_count,
   output int                    bookings_pending
);

   localparam int USE_LSB  = FIELD_SEAT_W;
   localparam int BUSY_LSB = USE_LSB + USE_W;
   localparam int PEAK_LSB = BUSY_LSB + FIELD_CNT_W;

   logic       seat_taken [NUM_SEATS];
   time_type   seat_until [NUM_SEATS];
   use_type    seat_uses  [NUM_SEATS];
   int         seats_busy;
   int         seats_peak;
   result_type booking_q [$];
   int         fail_tally = 0;

   function automatic result_type allocate_seat(input time_type start_t, input time_type end_t);
      result_type r;
      int         chosen;
      int         k;
      chosen = -1;
      for (k = 0; k < NUM_SEATS; k++) begin
         if (seat_taken[k] && seat_until[k] <= start_t) begin
            seat_taken[k] = 1'b0;
            seats_busy--;
         end
         if (!seat_taken[k] && chosen < 0)
            chosen = k;
      end
      r = '0;
      if (chosen < 0) begin
         r.status = 1'b1;
      end else begin
         seat_taken[chosen] = 1'b1;
         seat_until[chosen] = end_t;
         if (seat_uses[chosen] != USE_MAX)
            seat_uses[chosen] = seat_uses[chosen] + 1'b1;
         seats_busy++;
         if (seats_busy > seats_peak)
            seats_peak = seats_busy;
         r.seat_index     = FIELD_SEAT_W'(chosen);
         r.seat_use_count = seat_uses[chosen];
      end
      r.busy_count = FIELD_CNT_W'(seats_busy);
      r.peak_busy  = FIELD_CNT_W'(seats_peak);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input result_type want,
                                  input result_type got);
      fail_tally++;
      if (fail_tally <= 10)
         $display({"ERROR %0t: %s exp st=%0d seat=%0d use=%0d busy=%0d peak=%0d",
                   " got st=%0d seat=%0d use=%0d busy=%0d peak=%0d"},
                  $realtime, what, want.status, want.seat_index, want.seat_use_count,
                  want.busy_count, want.peak_busy, got.status, got.seat_index,
                  got.seat_use_count, got.busy_count, got.peak_busy);
   endtask

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         for (int k = 0; k < NUM_SEATS; k++) begin
            seat_taken[k] = 1'b0;
            seat_until[k] = '0;
            seat_uses[k]  = '0;
         end
         seats_busy = 0;
         seats_peak = 0;
         booking_q.delete();
      end else begin
         if (req_tvalid && req_tready)
            booking_q.push_back(allocate_seat(req_tdata[0 +: FIELD_TIME_W],
                                              req_tdata[FIELD_TIME_W +: FIELD_TIME_W]));
         if (rsp_tvalid && rsp_tready) begin
            got.status         = rsp_tuser;
            got.seat_index     = rsp_tdata[0 +: FIELD_SEAT_W];
            got.seat_use_count = rsp_tdata[USE_LSB +: USE_W];
            got.busy_count     = rsp_tdata[BUSY_LSB +: FIELD_CNT_W];
            got.peak_busy      = rsp_tdata[PEAK_LSB +: FIELD_CNT_W];
            if (booking_q.size() == 0) begin
               report_mismatch("result with no booking pending", '0, got);
            end else begin
               want = booking_q.pop_front();
               if (got.status !== want.status || got.seat_index !== want.seat_index ||
                   got.seat_use_count !== want.seat_use_count ||
                   got.busy_count !== want.busy_count || got.peak_busy !== want.peak_busy)
                  report_mismatch("booking result mismatch", want, got);
            end
         end
      end
      bookings_pending <= booking_q.size();
      error_count      <= fail_tally;
   end

endmodule

FILE: bench/lowest_free_seat_interval_allocator_top_tb.sv
// Testbench top for the seat allocator: clock, reset, booking stimulus and verdict.
module lowest_free_seat_interval_allocator_top_tb;
   import lfsia_pkg::*;

   localparam int RANDOM_PER_PHASE = 433;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // start_time, end_time
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // seat_index, seat_use_count, busy_count, peak_busy
   logic                  rsp_tuser;         // status

   int       error_count;
   int       bookings_pending;
   int       tx_idle_pct  = 0;
   int       rx_stall_pct = 0;
   int       flood_left   = 0;
   time_type now_t        = '0;

   lowest_free_seat_interval_allocator_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   lowest_free_seat_interval_allocator_checker u_check (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .error_count      (error_count),
      .bookings_pending (bookings_pending)
   );

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
   end

   task automatic send_booking(input time_type start_t, input time_type end_t);
      if ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 90)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {end_t, start_t};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_bookings();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (bookings_pending != 0) @(posedge clock);
   endtask

   // Mostly ordered traffic with random durations; floods of long bookings can fill every seat,
   // the rest is out-of-order starts, ends before starts and full-range noise.
   task automatic random_booking();
      int       pick;
      time_type start_t;
      time_type end_t;
      if (flood_left == 0 && $urandom_range(0, 99) < 1)
         flood_left = $urandom_range(60, 90);
      pick = $urandom_range(0, 99);
      if (flood_left > 0) begin
         flood_left--;
         now_t   = now_t + $urandom_range(0, 1);
         start_t = now_t;
         end_t   = now_t + $urandom_range(200, 1500);
      end else if (pick < 85) begin
         now_t   = now_t + $urandom_range(0, 40);
         start_t = now_t;
         end_t   = now_t + $urandom_range(0, 300);
      end else if (pick < 90) begin
         start_t = $urandom;
         end_t   = $urandom;
      end else if (pick < 95) begin
         start_t = now_t - $urandom_range(0, 100);
         end_t   = start_t + $urandom_range(0, 300);
      end else begin
         now_t   = now_t + $urandom_range(0, 40);
         start_t = now_t;
         end_t   = start_t - $urandom_range(1, 50);
      end
      send_booking(start_t, end_t);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, zero-length, end before start, out-of-order start
      send_booking(32'h0000_0000, 32'h0000_0000);
      send_booking(32'h0000_0000, 32'hFFFF_FFFF);
      send_booking(32'h0000_0005, 32'h0000_0003);
      send_booking(32'h0000_0005, 32'h0000_0064);
      send_booking(32'h0000_0002, 32'h0000_0032);
      send_booking(32'h0000_0064, 32'h0000_0064);
      send_booking(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_booking(32'hFFFF_FFFF, 32'h0000_0000);
      send_booking(32'h5555_5555, 32'hAAAA_AAAA);
      send_booking(32'hAAAA_AAAA, 32'h5555_5555);
      send_booking(32'h8000_0000, 32'h7FFF_FFFF);
      send_booking(32'h0000_0001, 32'hFFFF_FFFE);
      send_booking(32'hFFFF_FFFF, 32'h0000_0001);
      send_booking(32'h0000_0000, 32'h0000_0010);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 49; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 49; end
            default: begin tx_idle_pct = 32; rx_stall_pct = 32; end
         endcase
         drain_bookings();
         now_t = '0;
         if (ph == 0)
            flood_left = 70;
         for (int n = 0; n < RANDOM_PER_PHASE; n++)
            random_booking();
      end

      drain_bookings();
      repeat (NUM_SEATS + 10) @(posedge clock);
      if (error_count == 0)
         $display("lowest_free_seat_interval_allocator_top test passed");
      else
         $display("lowest_free_seat_interval_allocator_top test failed");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("lowest_free_seat_interval_allocator_top test failed");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/lfsia_pkg.sv
hw/rtl/lfsia_seat_mem.sv
hw/rtl/lfsia_ctrl.sv
hw/rtl/lowest_free_seat_interval_allocator_top.sv
hw/rtl/lfsia_checker.sv
bench/lowest_free_seat_interval_allocator_checker.sv
bench/lowest_free_seat_interval_allocator_top_tb.sv
